FILE: sv/sbs_pkg.sv
`timescale 1ns / 1ps
package sbs_pkg;

  // item field widths
  localparam int CMD_W   = 1;
  localparam int SLOT_W  = 5;
  localparam int PIX_W   = 12;
  localparam int PEL_W   = 8;
  localparam int COUNT_W = 6;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int LOW_W      = 11;
  localparam int HIGH_W     = 12;
  localparam int THR_W      = 6;
  localparam int LIMIT_W    = 15;
  localparam int BANDS      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RATIO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RATIO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT2     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT3     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT4     = 3'd7;

  localparam logic [LOW_W-1:0]   RST_LOW_RATIO  = 11'd614;
  localparam logic [HIGH_W-1:0]  RST_HIGH_RATIO = 12'd1707;
  localparam logic [THR_W-1:0]   RST_COUNT_THR  = 6'd23;
  localparam logic [LIMIT_W-1:0] RST_LIMIT0     = 15'd17;
  localparam logic [LIMIT_W-1:0] RST_LIMIT1     = 15'd15;
  localparam logic [LIMIT_W-1:0] RST_LIMIT2     = 15'd10;
  localparam logic [LIMIT_W-1:0] RST_LIMIT3     = 15'd8;
  localparam logic [LIMIT_W-1:0] RST_LIMIT4     = 15'd5;

  // commands
  localparam logic [CMD_W-1:0] CMD_STORE    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 1'b1;

  // luma band edges
  localparam logic [PEL_W-1:0] BAND_EDGE1 = 8'd50;
  localparam logic [PEL_W-1:0] BAND_EDGE2 = 8'd100;
  localparam logic [PEL_W-1:0] BAND_EDGE3 = 8'd150;
  localparam logic [PEL_W-1:0] BAND_EDGE4 = 8'd200;

  // chroma differences at or beyond these never match
  localparam logic [PEL_W-1:0] DU_SPAN = 8'd92;
  localparam logic [PEL_W-1:0] DV_SPAN = 8'd140;

  // stored sample: luma, u, v
  localparam int SAMPLE_W = 3 * PEL_W;

  typedef logic [LIMIT_W-1:0] limit_t;

endpackage

FILE: sv/sbs_in_if.sv
`timescale 1ns / 1ps
interface sbs_in_if;
  logic                          valid;
  logic                          ready;
  logic [sbs_pkg::CMD_W-1:0]     cmd;
  logic [sbs_pkg::SLOT_W-1:0]    sample_slot;
  logic [sbs_pkg::PIX_W-1:0]     pixel_index;
  logic [sbs_pkg::PEL_W-1:0]     luma;
  logic [sbs_pkg::PEL_W-1:0]     chroma_u;
  logic [sbs_pkg::PEL_W-1:0]     chroma_v;

  modport source (
    output valid, cmd, sample_slot, pixel_index, luma, chroma_u, chroma_v,
    input  ready
  );
  modport sink (
    input  valid, cmd, sample_slot, pixel_index, luma, chroma_u, chroma_v,
    output ready
  );
endinterface

FILE: sv/sbs_out_if.sv
`timescale 1ns / 1ps
interface sbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [sbs_pkg::PIX_W-1:0]     out_pixel_index;
  logic                          is_foreground;
  logic [sbs_pkg::COUNT_W-1:0]   match_count;

  modport source (
    output valid, out_pixel_index, is_foreground, match_count,
    input  ready
  );
  modport sink (
    input  valid, out_pixel_index, is_foreground, match_count,
    output ready
  );
endinterface

FILE: sv/sbs_ram.sv
`timescale 1ns / 1ps
module sbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/sample_background_subtractor_unit.sv
`timescale 1ns / 1ps
// Sample-based background subtractor. A store item (cmd 0) writes one
// (luma, u, v) sample into a slot of a pixel in the sample memory and gives no
// result; stores with an out-of-range slot or pixel are dropped. A classify
// item (cmd 1) reads all SAMPLES slots of its pixel from the memory, one slot
// per cycle, checks each against the luma ratio window and the chroma limit
// of the pixel's luma band, and returns the match count and a foreground flag
// (count below count_threshold). A classify is paced by the single read port of
// the sample memory and runs the read, product and compare stages; no new item
// is taken until it is done. The memory has no reset: every slot of a pixel must
// be stored before that pixel is classified. Configuration registers must be
// written through cfg_we/cfg_index/cfg_data only while idle; this is not enforced.
module sample_background_subtractor_unit #(
  parameter int SAMPLES = 32,
  parameter int PIXELS  = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sbs_in_if.sink                              in_chan,
  sbs_out_if.source                           out_chan,
  input  logic                                cfg_we,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SW     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int PW     = $clog2(PIXELS);
  localparam int ADDR_W = PW + SW;
  localparam int DEPTH  = PIXELS * (1 << SW);
  localparam int KW     = $clog2(SAMPLES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // configuration
  logic [sbs_pkg::LOW_W-1:0]  low_r;
  logic [sbs_pkg::HIGH_W-1:0] high_r;
  logic [sbs_pkg::THR_W-1:0]  thr_r;
  sbs_pkg::limit_t            limit_r [sbs_pkg::BANDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r      <= sbs_pkg::RST_LOW_RATIO;
      high_r     <= sbs_pkg::RST_HIGH_RATIO;
      thr_r      <= sbs_pkg::RST_COUNT_THR;
      limit_r[0] <= sbs_pkg::RST_LIMIT0;
      limit_r[1] <= sbs_pkg::RST_LIMIT1;
      limit_r[2] <= sbs_pkg::RST_LIMIT2;
      limit_r[3] <= sbs_pkg::RST_LIMIT3;
      limit_r[4] <= sbs_pkg::RST_LIMIT4;
    end else if (cfg_we) begin
      case (cfg_index)
        sbs_pkg::CFG_LOW_RATIO:  low_r      <= cfg_data[sbs_pkg::LOW_W-1:0];
        sbs_pkg::CFG_HIGH_RATIO: high_r     <= cfg_data[sbs_pkg::HIGH_W-1:0];
        sbs_pkg::CFG_COUNT_THR:  thr_r      <= cfg_data[sbs_pkg::THR_W-1:0];
        sbs_pkg::CFG_LIMIT0:     limit_r[0] <= cfg_data[sbs_pkg::LIMIT_W-1:0];
        sbs_pkg::CFG_LIMIT1:     limit_r[1] <= cfg_data[sbs_pkg::LIMIT_W-1:0];
        sbs_pkg::CFG_LIMIT2:     limit_r[2] <= cfg_data[sbs_pkg::LIMIT_W-1:0];
        sbs_pkg::CFG_LIMIT3:     limit_r[3] <= cfg_data[sbs_pkg::LIMIT_W-1:0];
        sbs_pkg::CFG_LIMIT4:     limit_r[4] <= cfg_data[sbs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input side
  logic [1:0] state_r, state_nxt;
  logic in_fire;
  logic is_store;
  logic pix_ok;
  logic slot_ok;
  sbs_pkg::limit_t band_limit;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign is_store = (in_chan.cmd == sbs_pkg::CMD_STORE);
  assign pix_ok   = 32'(in_chan.pixel_index) < PIXELS;
  assign slot_ok  = 32'(in_chan.sample_slot) < SAMPLES;

  always_comb begin
    if (in_chan.luma < sbs_pkg::BAND_EDGE1) begin
      band_limit = limit_r[0];
    end else if (in_chan.luma < sbs_pkg::BAND_EDGE2) begin
      band_limit = limit_r[1];
    end else if (in_chan.luma < sbs_pkg::BAND_EDGE3) begin
      band_limit = limit_r[2];
    end else if (in_chan.luma < sbs_pkg::BAND_EDGE4) begin
      band_limit = limit_r[3];
    end else begin
      band_limit = limit_r[4];
    end
  end

  // sequencer and classify context
  logic [KW-1:0]               k_r, k_nxt;
  logic [sbs_pkg::PIX_W-1:0]   pix_r;
  logic [sbs_pkg::PEL_W-1:0]   y_r, u_r, v_r;
  sbs_pkg::limit_t             lim_r;
  logic [KW-1:0]               count_r, count_nxt;

  // memory
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [sbs_pkg::SAMPLE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [sbs_pkg::SAMPLE_W-1:0] mem_rdata;

  assign mem_we    = in_fire && is_store && pix_ok && slot_ok;
  assign mem_waddr = {PW'(in_chan.pixel_index), SW'(in_chan.sample_slot)};
  assign mem_wdata = {in_chan.luma, in_chan.chroma_u, in_chan.chroma_v};
  assign mem_re    = (state_r == ST_READ);
  assign mem_raddr = {PW'(pix_r), SW'(k_r)};

  sbs_ram #(
    .WIDTH (sbs_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // read stage tags
  logic rd_v_r, rd_last_r;
  logic issue_last;

  assign issue_last = (32'(k_r) == SAMPLES - 1);

  // product stage
  logic [sbs_pkg::PEL_W-1:0] by, bu, bv, du, dv;
  logic [18:0] lo_prod_r;
  logic [19:0] hi_prod_r;
  logic [15:0] du_sq_r, dv_sq_r;
  logic        span_ok_r;
  logic        p_v_r, p_last_r;

  assign by = mem_rdata[3*sbs_pkg::PEL_W-1:2*sbs_pkg::PEL_W];
  assign bu = mem_rdata[2*sbs_pkg::PEL_W-1:sbs_pkg::PEL_W];
  assign bv = mem_rdata[sbs_pkg::PEL_W-1:0];
  assign du = (u_r >= bu) ? (u_r - bu) : (bu - u_r);
  assign dv = (v_r >= bv) ? (v_r - bv) : (bv - v_r);

  always_ff @(posedge clk) begin
    lo_prod_r <= 19'(low_r) * 19'(by);
    hi_prod_r <= 20'(high_r) * 20'(by);
    du_sq_r   <= 16'(du) * 16'(du);
    dv_sq_r   <= 16'(dv) * 16'(dv);
    span_ok_r <= (du < sbs_pkg::DU_SPAN) && (dv < sbs_pkg::DV_SPAN);
  end

  // compare stage
  logic [17:0] y_scaled;
  logic [16:0] chroma_dist;
  logic        luma_ok, chroma_ok, match;

  assign y_scaled    = {y_r, 10'd0};
  assign chroma_dist = 17'(du_sq_r) + 17'(dv_sq_r);
  assign luma_ok     = (lo_prod_r <= {1'b0, y_scaled}) && ({2'b00, y_scaled} <= hi_prod_r);
  assign chroma_ok   = span_ok_r && (chroma_dist <= 17'(lim_r));
  assign match       = p_v_r && luma_ok && chroma_ok;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [sbs_pkg::PIX_W-1:0]   out_pix_r;
  logic                        out_fg_r;
  logic [sbs_pkg::COUNT_W-1:0] out_count_r;
  logic                        out_load;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire && !is_store) begin
          k_nxt     = '0;
          count_nxt = '0;
          // a pixel outside the frame compares no samples
          state_nxt = pix_ok ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        k_nxt = k_r + KW'(1);
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end
        count_nxt = count_r + KW'(match);
      end
      ST_DRAIN: begin
        count_nxt = count_r + KW'(match);
        if (p_v_r && p_last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= mem_re;
      p_v_r       <= rd_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    count_r   <= count_nxt;
    rd_last_r <= mem_re && issue_last;
    p_last_r  <= rd_last_r;
    if (in_fire && !is_store) begin
      pix_r <= in_chan.pixel_index;
      y_r   <= in_chan.luma;
      u_r   <= in_chan.chroma_u;
      v_r   <= in_chan.chroma_v;
      lim_r <= band_limit;
    end
    if (out_load) begin
      out_pix_r   <= pix_r;
      out_fg_r    <= 32'(count_r) < 32'(thr_r);
      out_count_r <= (32'(count_r) > 63) ? '1 : sbs_pkg::COUNT_W'(count_r);
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.out_pixel_index = out_pix_r;
  assign out_chan.is_foreground   = out_fg_r;
  assign out_chan.match_count     = out_count_r;

endmodule
